>>> rtl/gb_pkg.sv
// ----------------------------------------------------------------------------
// gb_pkg
// Shared constants, register codes and types for the 5x5 Gaussian blur unit.
// ----------------------------------------------------------------------------
package gb_pkg;

    localparam int PIX_W        = 8;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_ADDR_W   = 1;

    localparam int WIN          = 5;
    localparam int LINES        = WIN - 1;
    localparam int HALF_WIN     = WIN / 2;
    localparam int MIN_DIM      = WIN;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 12'd480;

    // Division by 273 as a multiply by ceil(2^26 / 273) and a shift; exact for
    // every sum below 2^17.
    localparam int SUM_W       = 17;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd245821;

    localparam int QUEUE_DEPTH = 4;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // One column of the window: rows 0..3 from the line store, row 4 the new pixel.
    typedef struct packed {
        logic [WIN-1:0][PIX_W-1:0] column;
        logic                      produce;
        logic [COL_W-1:0]          ccol;
        logic [ROW_W-1:0]          crow;
    } col_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

endpackage

>>> rtl/gb_front.sv
// ----------------------------------------------------------------------------
// gb_front
// Raster counters, configuration registers and the four-row line store.
// Builds one window column per accepted pixel and pushes it to the queue.
// ----------------------------------------------------------------------------
module gb_front #(
    parameter int MAX_WIDTH = gb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gb_pkg::PIX_W-1:0]         s_pixel_in,
    input  logic                             cfg_wr_en,
    input  logic [gb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gb_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  gb_pkg::q_status_t                q_status,
    output logic                             push,
    output gb_pkg::col_item_t                push_item
);
    import gb_pkg::*;

    localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW  = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
    localparam int CXW = (CW > COL_W) ? CW : COL_W;
    localparam int LW  = LINES * PIX_W;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;

    logic                    v1_reg;
    logic [PIX_W-1:0]        px1_reg;
    logic [CW-1:0]           col1_reg;
    logic                    prod1_reg;
    logic [COL_W-1:0]        ccol1_reg;
    logic [ROW_W-1:0]        crow1_reg;
    logic [LW-1:0]           rd_reg;
    logic [LW-1:0]           line_mem [MAX_WIDTH];

    logic                    accept;
    logic [EW-1:0]           width_e, eff_w, col_inc;
    logic [ROW_W-1:0]        eff_h;
    logic [ROW_W:0]          row_inc;
    logic                    wrap;
    logic                    produce;
    logic [CXW-1:0]          col_ext;
    logic [QCNT_W:0]         occupancy;
    logic [WIN-1:0][PIX_W-1:0] column;
    logic [LW-1:0]           wr_word;

    // Room is reserved for the item whose line-store read is still in flight.
    assign occupancy = (QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(v1_reg);
    assign s_ready   = occupancy < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept    = s_valid && s_ready;

    always_comb begin
        width_e = EW'(width_reg);
        if (width_e < EW'(MIN_DIM)) begin
            eff_w = EW'(MIN_DIM);
        end else if (width_e > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = width_e;
        end
        eff_h   = (height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_reg;
        col_inc = EW'(col_reg) + EW'(1);
        row_inc = {1'b0, row_reg} + (ROW_W + 1)'(1);
        wrap    = col_inc >= eff_w;
        if (wrap) begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = (row_reg >= eff_h) ? '0 : row_reg;
        end
        col_ext = CXW'(col_reg);
        produce = (row_reg >= ROW_W'(LINES)) && (col_ext >= CXW'(LINES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            v1_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px1_reg   <= s_pixel_in;
            col1_reg  <= col_reg;
            prod1_reg <= produce;
            ccol1_reg <= COL_W'(col_ext - CXW'(HALF_WIN));
            crow1_reg <= row_reg - ROW_W'(HALF_WIN);
        end
    end

    // Each entry holds the four stored rows of one column. Read and write-back
    // of the same column are at least five pixels apart, so no forwarding.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[col_reg];
        end
        if (v1_reg) begin
            line_mem[col1_reg] <= wr_word;
        end
    end

    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            column[r] = rd_reg[r*PIX_W +: PIX_W];
        end
        column[LINES] = px1_reg;
        for (int r = 0; r < LINES; r++) begin
            wr_word[r*PIX_W +: PIX_W] = column[r+1];
        end
    end

    assign push              = v1_reg;
    assign push_item.column  = column;
    assign push_item.produce = prod1_reg;
    assign push_item.ccol    = ccol1_reg;
    assign push_item.crow    = crow1_reg;

endmodule

>>> rtl/gb_queue.sv
// ----------------------------------------------------------------------------
// gb_queue
// Short FIFO of window columns between the line-store front and the filter.
// ----------------------------------------------------------------------------
module gb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gb_pkg::col_item_t  push_item,
    input  logic               pop,
    output gb_pkg::col_item_t  pop_item,
    output gb_pkg::q_status_t  q_status
);
    import gb_pkg::*;

    col_item_t          entry_reg [QUEUE_DEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    function automatic logic [QADDR_W-1:0] ptr_inc(input logic [QADDR_W-1:0] p);
        return (p == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QADDR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item       = entry_reg[rd_ptr_reg];
    assign q_status.count = count_reg;
    assign q_status.empty = (count_reg == '0);

endmodule

>>> rtl/gb_back.sv
// ----------------------------------------------------------------------------
// gb_back
// 5x5 window registers and the weighted-sum / divide-by-273 pipeline.
// ----------------------------------------------------------------------------
module gb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gb_pkg::q_status_t             q_status,
    input  gb_pkg::col_item_t             pop_item,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gb_pkg::PIX_W-1:0]      m_filtered_pixel,
    output logic [gb_pkg::COL_W-1:0]      m_center_column,
    output logic [gb_pkg::ROW_W-1:0]      m_center_row
);
    import gb_pkg::*;

    localparam int G4_W = PIX_W + 2;
    localparam int G8_W = PIX_W + 3;
    localparam int PA_W = 14;
    localparam int PB_W = 16;
    localparam int PR_W = SUM_W + RECIP_W;

    logic [PIX_W-1:0] win_reg [WIN][WIN];

    logic             wv_reg, gv_reg, av_reg, sv_reg, pv_reg;
    logic [COL_W-1:0] wcol_reg, gcol_reg, acol_reg, scol_reg, pcol_reg;
    logic [ROW_W-1:0] wrow_reg, grow_reg, arow_reg, srow_reg, prow_reg;

    logic [G4_W-1:0]  g1_reg, g7_reg, g16_reg, g26_reg;
    logic [G8_W-1:0]  g4_reg;
    logic [PIX_W-1:0] gc_reg;
    logic [PA_W-1:0]  pa_reg;
    logic [PB_W-1:0]  pb_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PIX_W-1:0] quot_reg;
    logic [PR_W-1:0]  product;
    logic             en;

    function automatic logic [G4_W-1:0] add4(input logic [PIX_W-1:0] a, b, c, d);
        return G4_W'(a) + G4_W'(b) + G4_W'(c) + G4_W'(d);
    endfunction

    // The whole back end moves together; the queue absorbs its stalls.
    assign en  = !pv_reg || m_ready;
    assign pop = en && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= 1'b0;
            gv_reg <= 1'b0;
            av_reg <= 1'b0;
            sv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else if (en) begin
            wv_reg <= pop && pop_item.produce;
            gv_reg <= wv_reg;
            av_reg <= gv_reg;
            sv_reg <= av_reg;
            pv_reg <= sv_reg;
        end
    end

    // Every column slides into the window, whether or not it yields a result.
    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][WIN-1] <= pop_item.column[r];
            end
            wcol_reg <= pop_item.ccol;
            wrow_reg <= pop_item.crow;
        end
    end

    assign product = PR_W'(sum_reg) * PR_W'(RECIP_MULT);

    always_ff @(posedge aclk) begin
        if (en) begin
            // Pixels grouped by their mask weight.
            g1_reg  <= add4(win_reg[0][0], win_reg[0][4], win_reg[4][0], win_reg[4][4]);
            g4_reg  <= G8_W'(add4(win_reg[0][1], win_reg[0][3], win_reg[1][0], win_reg[1][4]))
                     + G8_W'(add4(win_reg[3][0], win_reg[3][4], win_reg[4][1], win_reg[4][3]));
            g7_reg  <= add4(win_reg[0][2], win_reg[2][0], win_reg[2][4], win_reg[4][2]);
            g16_reg <= add4(win_reg[1][1], win_reg[1][3], win_reg[3][1], win_reg[3][3]);
            g26_reg <= add4(win_reg[1][2], win_reg[2][1], win_reg[2][3], win_reg[3][2]);
            gc_reg  <= win_reg[2][2];
            gcol_reg <= wcol_reg;
            grow_reg <= wrow_reg;

            pa_reg <= PA_W'(g1_reg) + (PA_W'(g4_reg) << 2) + PA_W'(g7_reg) * PA_W'(7);
            pb_reg <= (PB_W'(g16_reg) << 4) + PB_W'(g26_reg) * PB_W'(26)
                    + PB_W'(gc_reg) * PB_W'(41);
            acol_reg <= gcol_reg;
            arow_reg <= grow_reg;

            sum_reg  <= SUM_W'(pa_reg) + SUM_W'(pb_reg);
            scol_reg <= acol_reg;
            srow_reg <= arow_reg;

            quot_reg <= product[RECIP_SHIFT +: PIX_W];
            pcol_reg <= scol_reg;
            prow_reg <= srow_reg;
        end
    end

    assign m_valid          = pv_reg;
    assign m_filtered_pixel = quot_reg;
    assign m_center_column  = pcol_reg;
    assign m_center_row     = prow_reg;

endmodule

>>> rtl/gaussian_blur_5x5_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_unit
// Streaming 5x5 Gaussian smoothing (mask sum 273) of an 8-bit grey frame.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_pixel_in
//   m_        out        m_valid / m_ready   m_filtered_pixel, m_center_column,
//                                            m_center_row
//   cfg_      in         cfg_wr_en           cfg_addr, cfg_wr_data
//
// One pixel per clock sustained while m_ready stays high. m_valid rises after
// the edge that accepts the pixel completing a window: the line-store read
// happens at that edge, then the column passes the column queue, the window
// shift and the filter pipeline. Reset clears counters and the pipeline; the
// line store is not cleared and needs no pass. When m_ready is held low the
// filter stops, the four-entry column queue fills, and s_ready then drops.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_unit #(
    parameter int MAX_WIDTH = gb_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gb_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gb_pkg::PIX_W-1:0]      m_filtered_pixel,
    output logic [gb_pkg::COL_W-1:0]      m_center_column,
    output logic [gb_pkg::ROW_W-1:0]      m_center_row,
    input  logic                          cfg_wr_en,
    input  logic [gb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gb_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import gb_pkg::*;

    q_status_t q_status;
    col_item_t push_item, pop_item;
    logic      push, pop;

    gb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    gb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    gb_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .pop_item         (pop_item),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_pixel (m_filtered_pixel),
        .m_center_column  (m_center_column),
        .m_center_row     (m_center_row)
    );

endmodule

>>> rtl/gb_checker.sv
// ----------------------------------------------------------------------------
// gb_checker
// Port-level checks on the Gaussian blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module gb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [gb_pkg::PIX_W-1:0]      s_pixel_in,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [gb_pkg::PIX_W-1:0]      m_filtered_pixel,
    input logic [gb_pkg::COL_W-1:0]      m_center_column,
    input logic [gb_pkg::ROW_W-1:0]      m_center_row
);
    import gb_pkg::*;

    // A stalled result must stay offered with its payload unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_pixel)
                             && $stable(m_center_column) && $stable(m_center_row))
        else $error("result dropped or changed while stalled");

    // A waiting request keeps its pixel until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_pixel_in))
        else $error("request withdrawn or changed while waiting");

    // Pixels on the top or left border are never produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_center_column >= COL_W'(HALF_WIN))
                 && (m_center_row >= ROW_W'(HALF_WIN)))
        else $error("result tagged on the frame border");

    // Reset empties the pipeline and the queue.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // A fresh result must not rise too soon after reset is released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(aresetn, 4))
        else $error("result appeared too soon after reset");

endmodule

bind gaussian_blur_5x5_unit gb_checker u_gb_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_pixel_in       (s_pixel_in),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filtered_pixel (m_filtered_pixel),
    .m_center_column  (m_center_column),
    .m_center_row     (m_center_row)
);
